>>> rtl/trig_equation_solver_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trigonometric equation solver
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIG_EQUATION_SOLVER_DEFINES_SVH
`define TRIG_EQUATION_SOLVER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define TEQS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define TEQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/teqs_pkg.sv
// ----------------------------------------------------------------------------
// teqs_pkg
// Shared types, codes and angle constants of the trigonometric equation solver.
// ----------------------------------------------------------------------------
`default_nettype none

package teqs_pkg;

    localparam int WIDE_FRAC  = 60;
    localparam int TABLE_LEN  = 32;
    localparam int SQRT_STEPS = 32;

    localparam logic signed [63:0] PI_WIDE = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0] HALF_PI = PI_WIDE >>> 1;

    localparam logic [1:0] FAIL_SOLVED = 2'd0;
    localparam logic [1:0] FAIL_DEGEN  = 2'd1;
    localparam logic [1:0] FAIL_RANGE  = 2'd2;

    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index REG_MAG_TOL = 1'b0;
    localparam t_cfg_index REG_ANG_TOL = 1'b1;

    typedef struct packed {
        logic signed [31:0] coeff_const;
        logic signed [31:0] coeff_cos;
        logic signed [31:0] coeff_sin;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         root_count;
        logic signed [31:0] first_angle;
        logic signed [31:0] second_angle;
        logic [1:0]         failure_code;
    } t_out_item;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic ypos;
        logic xzero;
        logic yzero;
    } t_atan_flags;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Term of the arctangent series: divide by the odd number 2k+1.
    function automatic logic [63:0] div_odd(input logic [63:0] v, input int k);
        case (k)
            0:       return v;
            1:       return v / 3;
            2:       return v / 5;
            3:       return v / 7;
            4:       return v / 9;
            5:       return v / 11;
            6:       return v / 13;
            7:       return v / 15;
            8:       return v / 17;
            9:       return v / 19;
            10:      return v / 21;
            11:      return v / 23;
            12:      return v / 25;
            13:      return v / 27;
            14:      return v / 29;
            15:      return v / 31;
            16:      return v / 33;
            17:      return v / 35;
            18:      return v / 37;
            19:      return v / 39;
            20:      return v / 41;
            21:      return v / 43;
            22:      return v / 45;
            23:      return v / 47;
            24:      return v / 49;
            25:      return v / 51;
            26:      return v / 53;
            27:      return v / 55;
            28:      return v / 57;
            29:      return v / 59;
            default: return v;
        endcase
    endfunction

    // atan(2^-idx) with 60 fraction bits, truncated series; elaboration only.
    function automatic logic signed [63:0] arc_entry(input int idx);
        logic signed [63:0] sum;
        logic [63:0]        term;
        int                 e;
        sum = '0;
        if (idx == 0) begin
            sum = PI_WIDE >>> 2;
        end else begin
            for (int k = 0; k < 30; k++) begin
                e = idx * (2 * k + 1);
                if (e <= WIDE_FRAC) begin
                    term = div_odd(64'(1) << (WIDE_FRAC - e), k);
                    if ((k & 1) != 0) sum = sum - signed'(term);
                    else              sum = sum + signed'(term);
                end
            end
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

>>> rtl/teqs_delay.sv
// ----------------------------------------------------------------------------
// teqs_delay
// Enabled shift line that carries side data alongside the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module teqs_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/teqs_sqrt.sv
// ----------------------------------------------------------------------------
// teqs_sqrt
// Pipelined restoring square root: floor(sqrt) of 64 bits, one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module teqs_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);

    import teqs_pkg::*;

    logic [63:0] r_rem [SQRT_STEPS-1];
    logic [63:0] r_res [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * s);
        logic [63:0] w_rem_in;
        logic [63:0] w_res_in;
        logic [63:0] w_try;
        logic        w_take;

        if (s == 0) begin : g_first
            assign w_rem_in = i_val;
            assign w_res_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_res_in = r_res[s-1];
        end

        assign w_try  = w_res_in + BIT;
        assign w_take = (w_rem_in >= w_try);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[s] <= w_take ? ((w_res_in >> 1) + BIT) : (w_res_in >> 1);
            end
        end

        if (s < SQRT_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_take ? (w_rem_in - w_try) : w_rem_in;
                end
            end
        end
    end

    assign o_root = r_res[SQRT_STEPS-1][31:0];

endmodule

`default_nettype wire

>>> rtl/teqs_cordic.sv
// ----------------------------------------------------------------------------
// teqs_cordic
// Pipelined vectoring CORDIC atan2 with staged normalization, 60-bit angle.
// ----------------------------------------------------------------------------
`default_nettype none

module teqs_cordic #(
    parameter int STAGES = 28
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [33:0] i_x,
    input  logic signed [33:0] i_y,
    output logic signed [63:0] o_angle
);

    import teqs_pkg::*;

    localparam int NW = 42;
    localparam int CW = 44;

    // Shift both magnitudes up by s while their OR stays below 2^41.
    function automatic logic [2*NW-1:0] norm_step(input logic [NW-1:0] ax,
                                                  input logic [NW-1:0] ay,
                                                  input int s);
        logic [NW-1:0] lim;
        lim = NW'(1) << (41 - s);
        if ((ax | ay) < lim) return {NW'(ax << s), NW'(ay << s)};
        return {ax, ay};
    endfunction

    logic [NW-1:0]      r_nx [4];
    logic [NW-1:0]      r_ny [4];
    t_atan_flags        r_nf [4];
    logic signed [CW-1:0] r_cx [STAGES];
    logic signed [CW-1:0] r_cy [STAGES];
    logic signed [63:0] r_z  [STAGES];
    t_atan_flags        r_cf [STAGES];
    logic signed [63:0] r_angle;

    logic [33:0] w_ax;
    logic [33:0] w_ay;

    assign w_ax = i_x[33] ? 34'(-i_x) : 34'(i_x);
    assign w_ay = i_y[33] ? 34'(-i_y) : 34'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx[0]       <= NW'(w_ax);
            r_ny[0]       <= NW'(w_ay);
            r_nf[0].xneg  <= i_x[33];
            r_nf[0].yneg  <= i_y[33];
            r_nf[0].ypos  <= !i_y[33] && (i_y != '0);
            r_nf[0].xzero <= (i_x == '0);
            r_nf[0].yzero <= (i_y == '0);
        end
    end

    // Normalize: shifts 32,16 then 8,4 then 2,1.
    for (genvar p = 1; p < 4; p++) begin : g_norm
        logic [2*NW-1:0] w_hi;
        logic [2*NW-1:0] w_lo;
        assign w_hi = norm_step(r_nx[p-1], r_ny[p-1], 128 >> (2 * p));
        assign w_lo = norm_step(w_hi[2*NW-1:NW], w_hi[NW-1:0], 64 >> (2 * p));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[p] <= w_lo[2*NW-1:NW];
                r_ny[p] <= w_lo[NW-1:0];
                r_nf[p] <= r_nf[p-1];
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        localparam logic signed [63:0] ARC = arc_entry(i);
        logic signed [CW-1:0] w_px;
        logic signed [CW-1:0] w_py;
        logic signed [63:0]   w_pz;
        t_atan_flags          w_pf;
        logic signed [CW-1:0] w_dx;
        logic signed [CW-1:0] w_dy;

        if (i == 0) begin : g_first
            assign w_px = signed'(CW'(r_nx[3]));
            assign w_py = signed'(CW'(r_ny[3]));
            assign w_pz = '0;
            assign w_pf = r_nf[3];
        end else begin : g_next
            assign w_px = r_cx[i-1];
            assign w_py = r_cy[i-1];
            assign w_pz = r_z[i-1];
            assign w_pf = r_cf[i-1];
        end

        assign w_dx = w_py >>> i;
        assign w_dy = w_px >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_py[CW-1]) begin
                    r_cx[i] <= w_px + w_dx;
                    r_cy[i] <= w_py - w_dy;
                    r_z[i]  <= w_pz + ARC;
                end else begin
                    r_cx[i] <= w_px - w_dx;
                    r_cy[i] <= w_py + w_dy;
                    r_z[i]  <= w_pz - ARC;
                end
                r_cf[i] <= w_pf;
            end
        end
    end

    t_atan_flags        w_f;
    logic signed [63:0] w_z1;
    logic signed [63:0] w_z2;

    assign w_f  = r_cf[STAGES-1];
    assign w_z1 = w_f.xneg ? (PI_WIDE - r_z[STAGES-1]) : r_z[STAGES-1];
    assign w_z2 = w_f.yneg ? -w_z1 : w_z1;

    // Fold the quadrant back; axis cases bypass the rotation.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_f.yzero) begin
                r_angle <= w_f.xneg ? PI_WIDE : '0;
            end else if (w_f.xzero) begin
                r_angle <= w_f.ypos ? HALF_PI : -HALF_PI;
            end else begin
                r_angle <= w_z2;
            end
        end
    end

    assign o_angle = r_angle;

endmodule

`default_nettype wire

>>> rtl/trig_equation_solver.sv
// ----------------------------------------------------------------------------
// trig_equation_solver
// Solves a + b cos(theta) + c sin(theta) = 0 for theta, one item per cycle while o_stall is low.
// ----------------------------------------------------------------------------
// Each item carries a, b, c in signed fixed point and returns zero to two
// angles in Q3.28 radians with a failure code. The block is fully pipelined:
// it takes a new item every clock while o_stall is low. Each item passes the
// 32-stage square root (one root bit per stage), then the CORDIC arctangent
// (four stages of normalization, one stage per rotation, one stage of
// quadrant fixup) and then the final angle sum and root decision. A two-entry
// output buffer (output register plus skid) parts the sides, so o_stall
// rises only after a result has waited in both; while it is high the whole
// pipeline holds.
// Configuration is a plain write port and may change only while idle.
`default_nettype none
`include "trig_equation_solver_defines.svh"

module trig_equation_solver #(
    parameter int INPUT_FRACTION_BITS = 16,
    parameter int ANGLE_FRACTION_BITS = 28,
    parameter int CORDIC_STAGES       = 28
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  teqs_pkg::t_in_item    i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output teqs_pkg::t_out_item   o_item,
    input  logic                  i_cfg_wr_en,
    input  teqs_pkg::t_cfg_index  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    import teqs_pkg::*;

    localparam int SH        = WIDE_FRAC - ANGLE_FRACTION_BITS;
    localparam int TOL_LIM   = 62 - SH;
    localparam int LAT       = CORDIC_STAGES + 43;
    localparam int ABC_DEPTH = SQRT_STEPS + 3;
    localparam int FAIL_DEPTH = CORDIC_STAGES + 3;
    localparam logic [31:0] ONE_IN = 32'(1) << INPUT_FRACTION_BITS;
    localparam logic signed [63:0] RND = 64'(1) << (SH - 1);

    // Configuration registers.
    logic [15:0] r_mtol;
    logic [15:0] r_atol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtol <= 16'd1;
            r_atol <= 16'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MAG_TOL: r_mtol <= i_cfg_data;
                REG_ANG_TOL: r_atol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: hold everything while the skid entry is occupied.
    logic r_skid_valid;
    logic r_out_valid;
    logic w_en;
    logic w_acc;
    logic [LAT-1:0] r_vld;

    assign w_en    = !r_skid_valid;
    assign w_acc   = i_valid && w_en;
    assign o_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    // Stage 1: capture and take magnitudes.
    logic signed [31:0] r_s1_a, r_s1_b, r_s1_c;
    logic [31:0]        r_s1_ua, r_s1_ub, r_s1_uc;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_a  <= i_item.coeff_const;
            r_s1_b  <= i_item.coeff_cos;
            r_s1_c  <= i_item.coeff_sin;
            r_s1_ua <= mag32(i_item.coeff_const);
            r_s1_ub <= mag32(i_item.coeff_cos);
            r_s1_uc <= mag32(i_item.coeff_sin);
        end
    end

    // Stage 2: squares.
    logic [63:0] r_s2_a2, r_s2_b2, r_s2_c2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_a2 <= r_s1_ua * r_s1_ua;
            r_s2_b2 <= r_s1_ub * r_s1_ub;
            r_s2_c2 <= r_s1_uc * r_s1_uc;
        end
    end

    // Stage 3: b^2 + c^2. Stage 4: radicand of the sine term, floored at zero.
    logic [63:0] r_s3_sq, r_s3_a2, r_s4_sq, r_s4_diff;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_sq   <= r_s2_b2 + r_s2_c2;
            r_s3_a2   <= r_s2_a2;
            r_s4_sq   <= r_s3_sq;
            r_s4_diff <= (r_s3_a2 >= r_s3_sq) ? '0 : (r_s3_sq - r_s3_a2);
        end
    end

    // Carry the coefficients past the square roots.
    logic [95:0]        w_abc_d;
    logic signed [31:0] w_a36, w_b36, w_c36;

    teqs_delay #(.WIDTH(96), .DEPTH(ABC_DEPTH)) u_abc_delay (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_s1_a, r_s1_b, r_s1_c}),
        .o_q   (w_abc_d)
    );

    assign w_a36 = signed'(w_abc_d[95:64]);
    assign w_b36 = signed'(w_abc_d[63:32]);
    assign w_c36 = signed'(w_abc_d[31:0]);

    logic [31:0] w_amp;
    logic [31:0] w_ys;

    teqs_sqrt u_amp_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_s4_sq),
        .o_root (w_amp)
    );

    teqs_sqrt u_sine_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_s4_diff),
        .o_root (w_ys)
    );

    // Phase = atan2(c, b); delta = atan2(sine term, -a).
    logic signed [63:0] w_phase;
    logic signed [63:0] w_delta;

    teqs_cordic #(.STAGES(CORDIC_STAGES)) u_phase_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (34'(w_b36)),
        .i_y     (34'(w_c36)),
        .o_angle (w_phase)
    );

    teqs_cordic #(.STAGES(CORDIC_STAGES)) u_delta_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (-(34'(w_a36))),
        .i_y     (signed'({2'b00, w_ys})),
        .o_angle (w_delta)
    );

    // Amplitude checks, beside the CORDIC.
    logic        r_c1_deg;
    logic [63:0] r_c1_prod;
    logic [63:0] r_c1_uaf;
    logic [1:0]  r_c2_fail;
    logic [31:0] w_scale;

    assign w_scale = ONE_IN + 32'(r_mtol);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_deg  <= (w_amp < 32'(r_mtol));
            r_c1_prod <= w_amp * w_scale;
            r_c1_uaf  <= 64'(mag32(w_a36)) << INPUT_FRACTION_BITS;
            if (r_c1_deg)                    r_c2_fail <= FAIL_DEGEN;
            else if (r_c1_uaf > r_c1_prod)   r_c2_fail <= FAIL_RANGE;
            else                             r_c2_fail <= FAIL_SOLVED;
        end
    end

    logic [1:0] w_fail_d;

    teqs_delay #(.WIDTH(2), .DEPTH(FAIL_DEPTH)) u_fail_delay (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_c2_fail),
        .o_q   (w_fail_d)
    );

    // Angle tolerance widened to 60 fraction bits, saturated at 2^62.
    logic [63:0] w_tolw;

    assign w_tolw = ((64'(r_atol) >> TOL_LIM) != '0) ? (64'(1) << 62)
                                                     : (64'(r_atol) << SH);

    // Final stage 1: root sums with rounding bias, distance from pi.
    logic signed [63:0] r_f1_sum, r_f1_dif, r_f1_dmp, r_f1_pmd;
    logic               r_f1_gt;
    logic [1:0]         r_f1_fail;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_sum  <= w_phase + w_delta + RND;
            r_f1_dif  <= w_phase - w_delta + RND;
            r_f1_dmp  <= w_delta - PI_WIDE;
            r_f1_pmd  <= PI_WIDE - w_delta;
            r_f1_gt   <= (unsigned'(w_delta) > w_tolw);
            r_f1_fail <= w_fail_d;
        end
    end

    // Final stage 2: decide on the second root and build the result item.
    logic signed [63:0] w_dpi;
    logic               w_second;
    t_out_item          n_res;
    t_out_item          r_res;

    assign w_dpi    = r_f1_dmp[63] ? r_f1_pmd : r_f1_dmp;
    assign w_second = r_f1_gt && (unsigned'(w_dpi) > w_tolw);

    always_comb begin
        n_res              = '0;
        n_res.failure_code = r_f1_fail;
        if (r_f1_fail == FAIL_SOLVED) begin
            n_res.first_angle = 32'(r_f1_sum >>> SH);
            if (w_second) begin
                n_res.second_angle = 32'(r_f1_dif >>> SH);
                n_res.root_count   = 2'd2;
            end else begin
                n_res.root_count   = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= n_res;
        end
    end

    // Output register plus skid entry.
    t_out_item r_out_item;
    t_out_item r_skid_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= r_vld[LAT-1];
            end
        end else if (r_vld[LAT-1] && w_en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out_item <= r_skid_valid ? r_skid_item : r_res;
        end else if (w_en) begin
            r_skid_item <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    `TEQS_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full while output empty")
    `TEQS_ASSERT_SAME(a_fail_no_roots, o_valid && (o_item.failure_code != FAIL_SOLVED), (o_item.root_count == 2'd0) && (o_item.first_angle == '0) && (o_item.second_angle == '0), "failed item carries roots")
    `TEQS_ASSERT_SAME(a_solved_roots, o_valid && (o_item.failure_code == FAIL_SOLVED), (o_item.root_count == 2'd1) || (o_item.root_count == 2'd2), "solved item without roots")
    `TEQS_ASSERT_NEXT(a_hold_on_skid, r_skid_valid, $stable(r_vld), "pipeline advanced while skid full")

endmodule

`default_nettype wire
